/* src/conv2d_window_filter_core_assert.svh */
// Assertion macros for the convolution window filter.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONV2D_WINDOW_FILTER_CORE_ASSERT_SVH
`define CONV2D_WINDOW_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CWF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwf assertion failed");
`define CWF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwf assertion failed");
`else
`define CWF_ASSERT_NOW(label, ante, cons)
`define CWF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/cwf_pkg.sv */
// Shared types and constants of the convolution window filter.
// No dependencies.
package cwf_pkg;
	localparam int PIX_W   = 8;
	localparam int COEF_W  = 18;
	localparam int CIDX_W  = 5;
	localparam int POS_W   = 10;
	localparam int FILT_W  = 31;
	localparam int CFG_W   = 11;
	localparam int CFGI_W  = 2;
	localparam int KSZ_W   = 4;
	localparam int PROD_W  = 27;

	localparam logic [CFGI_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [2:0]       RST_KERNEL_SIZE  = 3'd5;

	localparam logic MODE_COEF  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct packed {
		logic accept;
		logic shift;
		logic mac_clr;
		logic mac_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic mac_last;
		logic out_full;
		logic is_pixel;
	} sts_t;
endpackage

/* src/cwf_if.sv */
// Stream and configuration channel interfaces of the convolution window filter.
// Depends on cwf_pkg.
interface cwf_in_if;
	logic                               valid;
	logic                               ready;
	logic                               mode;
	logic [cwf_pkg::CIDX_W-1:0]         coef_index;
	logic signed [cwf_pkg::COEF_W-1:0]  coef_value;
	logic [cwf_pkg::PIX_W-1:0]          pixel;
	modport source (output valid, mode, coef_index, coef_value, pixel, input ready);
	modport sink (input valid, mode, coef_index, coef_value, pixel, output ready);
endinterface

interface cwf_out_if;
	logic                               valid;
	logic                               ready;
	logic [cwf_pkg::POS_W-1:0]          out_row;
	logic [cwf_pkg::POS_W-1:0]          out_col;
	logic signed [cwf_pkg::FILT_W-1:0]  filtered;
	modport source (output valid, out_row, out_col, filtered, input ready);
	modport sink (input valid, out_row, out_col, filtered, output ready);
endinterface

interface cwf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cwf_pkg::CFGI_W-1:0]         index;
	logic [cwf_pkg::CFG_W-1:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/cwf_ctrl.sv */
// Sequencer of the convolution window filter: accept, shift, MAC, output.
// Depends on cwf_pkg and the assertion macro header.
`include "conv2d_window_filter_core_assert.svh"
module cwf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	output logic          in_ready,
	input  cwf_pkg::sts_t sts,
	output cwf_pkg::cmd_t cmd
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_mode == cwf_pkg::MODE_PIXEL) state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				cmd.mac_clr = 1'b1;
				state_d = sts.emit ? ST_MAC : ST_IDLE;
			end
			ST_MAC: begin
				cmd.mac_step = 1'b1;
				if (sts.mac_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_PUSH;
			ST_PUSH: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	`CWF_ASSERT_NEXT(a_mac_to_drain, state_q == ST_MAC && sts.mac_last, state_q == ST_DRAIN)
	`CWF_ASSERT_NOW(a_load_when_free, cmd.load_out, !sts.out_full)
	`CWF_ASSERT_NEXT(a_pixel_goes_shift, cmd.accept && sts.is_pixel, state_q == ST_SHIFT)
endmodule

/* src/cwf_datapath.sv */
// Datapath: config registers, counters, line store, window, weights, MAC, output register.
// Depends on cwf_pkg and the channel interfaces.
module cwf_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_KERNEL = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	cwf_in_if.sink        in_ch,
	cwf_out_if.source     out_ch,
	cwf_cfg_if.sink       cfg,
	input  cwf_pkg::cmd_t cmd,
	output cwf_pkg::sts_t sts
);
	localparam int NW      = MAX_KERNEL * MAX_KERNEL;
	localparam int LS_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
	localparam int AW      = $clog2(MAX_WIDTH);
	localparam int KW      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int WIW     = (NW > 1) ? $clog2(NW) : 1;
	localparam int ACC_RAW = cwf_pkg::PROD_W + 1 + $clog2(NW);
	localparam int ACC_W   = (ACC_RAW < cwf_pkg::FILT_W) ? cwf_pkg::FILT_W : ACC_RAW;
	localparam int W_HI    = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int PW      = cwf_pkg::PIX_W;

	// configuration
	logic [cwf_pkg::CFG_W-1:0] width_q, height_q;
	logic [2:0]                ksize_q;
	logic [cwf_pkg::CFG_W-1:0] w_eff, h_eff;
	logic [cwf_pkg::KSZ_W-1:0] k_eff, b_eff;
	logic                      cfg_hit;

	assign cfg.ready = 1'b1;
	assign cfg_hit = cfg.valid && (cfg.index == cwf_pkg::CFG_IMAGE_WIDTH ||
		cfg.index == cwf_pkg::CFG_IMAGE_HEIGHT || cfg.index == cwf_pkg::CFG_KERNEL_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cwf_pkg::RST_IMAGE_WIDTH;
			height_q <= cwf_pkg::RST_IMAGE_HEIGHT;
			ksize_q  <= cwf_pkg::RST_KERNEL_SIZE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cwf_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg.data;
				cwf_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg.data;
				cwf_pkg::CFG_KERNEL_SIZE:  ksize_q  <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) w_eff = 11'd1;
		else if (int'(width_q) > W_HI) w_eff = 11'(W_HI);
		else w_eff = width_q;
		if (height_q == '0) h_eff = 11'd1;
		else if (height_q > 11'd1024) h_eff = 11'd1024;
		else h_eff = height_q;
		if (ksize_q == '0) k_eff = 4'd1;
		else if (int'(ksize_q) > MAX_KERNEL) k_eff = 4'(MAX_KERNEL);
		else k_eff = 4'(ksize_q);
		b_eff = k_eff >> 1;
	end

	// position and emit decision at accept
	logic [cwf_pkg::POS_W-1:0] row_q, col_q;
	logic [11:0]               r1, c1, ci, cj;
	logic                      emit_now;
	logic                      emit_q;
	logic [cwf_pkg::POS_W-1:0] ci_q, cj_q;
	logic [AW-1:0]             addr_q;
	logic [PW-1:0]             px_q;
	logic [13:0]               col_ext;
	logic                      pix_acc;

	assign pix_acc = cmd.accept && in_ch.mode == cwf_pkg::MODE_PIXEL;
	assign r1 = 12'(row_q) + 12'd1;
	assign c1 = 12'(col_q) + 12'd1;
	assign ci = r1 - 12'(k_eff) + 12'(b_eff);
	assign cj = c1 - 12'(k_eff) + 12'(b_eff);
	assign emit_now = r1 >= 12'(k_eff) && c1 >= 12'(k_eff) &&
		(ci + 12'(b_eff)) < 12'(h_eff) && (cj + 12'(b_eff)) < 12'(w_eff);
	assign col_ext = 14'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pix_acc) begin
			if (c1 >= 12'(w_eff)) begin
				col_q <= '0;
				if (r1 >= 12'(h_eff)) row_q <= '0;
				else row_q <= r1[cwf_pkg::POS_W-1:0];
			end else begin
				col_q <= c1[cwf_pkg::POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			emit_q <= emit_now;
			ci_q   <= ci[cwf_pkg::POS_W-1:0];
			cj_q   <= cj[cwf_pkg::POS_W-1:0];
			addr_q <= col_ext[AW-1:0];
			px_q   <= in_ch.pixel;
		end
	end

	// line store: one word per column holds the previous rows
	logic [LS_ROWS*PW-1:0] ls_mem [MAX_WIDTH];
	logic [LS_ROWS*PW-1:0] ls_rd_q, ls_wd;

	always_ff @(posedge clk) begin
		if (pix_acc) ls_rd_q <= ls_mem[col_ext[AW-1:0]];
		if (cmd.shift) ls_mem[addr_q] <= ls_wd;
	end

	always_comb begin
		ls_wd = ls_rd_q;
		ls_wd[PW-1:0] = px_q;
		for (int dr = 1; dr < LS_ROWS; dr++) ls_wd[dr*PW +: PW] = ls_rd_q[(dr-1)*PW +: PW];
	end

	// window registers
	logic [PW-1:0] win_q [MAX_KERNEL][MAX_KERNEL];

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int dr = 0; dr < MAX_KERNEL; dr++)
				for (int dc = MAX_KERNEL - 1; dc > 0; dc--) win_q[dr][dc] <= win_q[dr][dc-1];
			win_q[0][0] <= px_q;
			for (int dr = 1; dr < MAX_KERNEL; dr++) win_q[dr][0] <= ls_rd_q[(dr-1)*PW +: PW];
		end
	end

	// weights
	logic signed [cwf_pkg::COEF_W-1:0] wt_q [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) wt_q[i] <= '0;
		end else if (cmd.accept && in_ch.mode == cwf_pkg::MODE_COEF &&
			int'(in_ch.coef_index) < NW) begin
			wt_q[WIW'(in_ch.coef_index)] <= in_ch.coef_value;
		end
	end

	// multiply-accumulate, one tap per cycle
	logic [KW-1:0]                      a_q, d_q;
	logic [WIW-1:0]                     widx_q;
	logic signed [cwf_pkg::PROD_W-1:0]  prod_s1;
	logic                               pv_s1;
	logic signed [ACC_W-1:0]            acc_q;
	logic                               d_last, a_last;

	assign d_last = 4'(d_q) == k_eff - 4'd1;
	assign a_last = 4'(a_q) == k_eff - 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mac_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_clr) begin
			a_q <= '0;
			d_q <= '0;
			widx_q <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.mac_step) begin
				widx_q <= widx_q + 1'b1;
				if (d_last) begin
					d_q <= '0;
					a_q <= a_q + 1'b1;
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			if (pv_s1) acc_q <= acc_q + ACC_W'(prod_s1);
		end
		prod_s1 <= wt_q[widx_q] * $signed({1'b0, win_q[a_q][d_q]});
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ch.out_row  <= ci_q;
			out_ch.out_col  <= cj_q;
			out_ch.filtered <= acc_q[cwf_pkg::FILT_W-1:0];
		end
	end

	assign out_ch.valid = out_valid_q;

	assign sts.emit     = emit_q;
	assign sts.mac_last = d_last && a_last;
	assign sts.out_full = out_valid_q;
	assign sts.is_pixel = in_ch.mode == cwf_pkg::MODE_PIXEL;
endmodule

/* src/conv2d_window_filter_core.sv */
// Top level of the K by K convolution window filter over a raster pixel stream.
// Depends on cwf_pkg, the channel interfaces, cwf_ctrl and cwf_datapath.
//
//  channel  dir  payload                               handshake
//  in_ch    in   mode, coef_index, coef_value, pixel   valid/ready
//  out_ch   out  out_row, out_col, filtered            valid/ready
//  cfg      in   index, data                           valid/ready (always ready)
//
// A coefficient beat is taken in the idle state alone. A pixel beat passes through the
// line store read and the window shift when no result is due, else also through the
// MAC loop, one tap a cycle on its single multiplier, then a drain and an output load.
// The finished result waits in the output register; a stalled sink only holds
// the block once the next result is ready to go.
// Reset clears control, the position counters, configuration and weights; line store and
// window hold whatever they held until written.
module conv2d_window_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_KERNEL = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	cwf_in_if.sink    in_ch,
	cwf_out_if.source out_ch,
	cwf_cfg_if.sink   cfg
);
	cwf_pkg::cmd_t cmd;
	cwf_pkg::sts_t sts;

	// sequencer: owns in_ch.ready and all stepping
	cwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_mode  (in_ch.mode),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	cwf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_KERNEL (MAX_KERNEL)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule
